// File: src/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Motor panel controller package
// Shared types, switch codes, drive pin codes and display tables.
// ----------------------------------------------------------------------------
package mpc_pkg;

	// Active-low switch patterns that mean something; anything else is ignored.
	localparam logic [5:0] SW_DUTY25  = 6'b111110;
	localparam logic [5:0] SW_DUTY50  = 6'b111101;
	localparam logic [5:0] SW_DUTY70  = 6'b111011;
	localparam logic [5:0] SW_DUTY90  = 6'b110111;
	localparam logic [5:0] SW_REVERSE = 6'b101111;
	localparam logic [5:0] SW_STOP    = 6'b011111;

	// Operation codes of a request.
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Drive pin codes: bit 1 is the forward pin, bit 0 the reverse pin.
	localparam logic [1:0] PIN_OFF     = 2'b00;
	localparam logic [1:0] PIN_REVERSE = 2'b01;
	localparam logic [1:0] PIN_FORWARD = 2'b10;
	localparam logic [1:0] PIN_BRAKE   = 2'b11;

	// Display digit positions.
	localparam logic [1:0] POS_BLANK = 2'd0;
	localparam logic [1:0] POS_SIGN  = 2'd1;
	localparam logic [1:0] POS_TENS  = 2'd2;
	localparam logic [1:0] POS_UNITS = 2'd3;

	// Active-low segment patterns.
	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [7:0] SEG_MINUS = 8'hBF;

	localparam logic [7:0] REVERSE_WAIT_RESET = 8'd100;

	// Decoded switch sample.
	typedef struct packed {
		logic       set_duty;
		logic [6:0] duty;
		logic       reverse;
		logic       stop;
	} key_t;

	function automatic logic [7:0] seg_digit(input logic [3:0] value);
		logic [7:0] pattern;
		unique case (value)
			4'd0:    pattern = 8'hC0;
			4'd1:    pattern = 8'hF9;
			4'd2:    pattern = 8'hA4;
			4'd3:    pattern = 8'hB0;
			4'd4:    pattern = 8'h99;
			4'd5:    pattern = 8'h92;
			4'd6:    pattern = 8'h82;
			4'd7:    pattern = 8'hF8;
			4'd8:    pattern = 8'h80;
			4'd9:    pattern = 8'h90;
			default: pattern = SEG_BLANK;
		endcase
		return pattern;
	endfunction

	// The duty only ever holds 0, 25, 50, 70 or 90 percent, so the
	// compare value and the two digits come from small tables.
	function automatic logic [7:0] duty_to_compare(input logic [6:0] duty);
		logic [7:0] cmp;
		unique case (duty)
			7'd25:   cmp = 8'd63;
			7'd50:   cmp = 8'd127;
			7'd70:   cmp = 8'd178;
			7'd90:   cmp = 8'd229;
			default: cmp = 8'd0;
		endcase
		return cmp;
	endfunction

	function automatic logic [3:0] duty_tens(input logic [6:0] duty);
		logic [3:0] tens;
		unique case (duty)
			7'd25:   tens = 4'd2;
			7'd50:   tens = 4'd5;
			7'd70:   tens = 4'd7;
			7'd90:   tens = 4'd9;
			default: tens = 4'd0;
		endcase
		return tens;
	endfunction

	function automatic logic [3:0] duty_units(input logic [6:0] duty);
		logic [3:0] units;
		unique case (duty)
			7'd25:   units = 4'd5;
			default: units = 4'd0;
		endcase
		return units;
	endfunction

endpackage

// File: src/mpc_if.sv
// ----------------------------------------------------------------------------
// Motor panel controller channels
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface mpc_req_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [5:0] switches;

	modport source (output valid, output operation, output switches, input ready);
	modport sink (input valid, input operation, input switches, output ready);
endinterface

interface mpc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty_compare;
	logic [1:0] drive_pins;
	logic [1:0] digit_select;
	logic [7:0] segments;
	logic       reversing;

	modport source (output valid, output duty_compare, output drive_pins,
		output digit_select, output segments, output reversing, input ready);
	modport sink (input valid, input duty_compare, input drive_pins,
		input digit_select, input segments, input reversing, output ready);
endinterface

// File: src/motor_panel_controller.sv
// ----------------------------------------------------------------------------
// Motor panel controller
// Duty, direction and drive control of a DC motor with a four-digit display.
// ----------------------------------------------------------------------------
// Each request is either a 5 ms display tick or a sample of six active-low
// switches, and each request yields exactly one result. A request enters an
// input register, and from there its decode and state update run through a
// short stretch of logic into the result register, so the block takes one
// request per clock cycle while the sink keeps taking results. Both registers
// advance independently, which means a new request is taken while a finished
// result still waits for the sink. The duty keys select 25, 50, 70 or 90
// percent and the result carries the PWM compare value duty*255/100. The
// reverse key turns the drive off and starts a wait of reverse_wait_ticks
// display ticks (a value of zero waits 256 ticks), after which the opposite
// direction is driven; switch samples are ignored while the wait runs. The
// stop key zeroes the duty and brakes with both pins high. Ticks step through
// the four digits: a blank, a minus sign in reverse, then tens and units. The
// wait register is written through cfg_we and cfg_wdata; the user is to write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module motor_panel_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	mpc_req_if.sink     req,
	mpc_rsp_if.source   rsp
);
	import mpc_pkg::*;

	// Pipeline control.
	logic       valid_s1;
	logic       operation_s1;
	logic [5:0] switches_s1;
	logic       valid_s2;
	logic       load_s2;
	logic       req_accept;

	// Block state.
	logic [7:0] reverse_wait_ticks_q;
	logic [6:0] duty_q;
	logic       forward_q;
	logic [1:0] pin_state_q;
	logic [7:0] wait_count_q;
	logic       wait_active_q;
	logic [1:0] mux_position_q;
	logic       tens_shown_q;

	logic [6:0] duty_d;
	logic       forward_d;
	logic [1:0] pin_state_d;
	logic [7:0] wait_count_d;
	logic       wait_active_d;
	logic [1:0] mux_position_d;
	logic       tens_shown_d;

	// Result registers.
	logic [7:0] duty_compare_s2;
	logic [1:0] digit_select_s2;
	logic [7:0] segments_s2;

	key_t       key;
	logic [7:0] digit_segments;
	logic [7:0] wait_count_inc;

	// The result register loads whenever it is empty or being drained, and
	// the input register refills whenever its content moves on.
	assign load_s2    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready  = !valid_s1 || load_s2;
	assign req_accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_accept || (valid_s1 && !load_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			operation_s1 <= req.operation;
			switches_s1  <= req.switches;
		end
	end

	mpc_key_decode u_key_decode (
		.switches (switches_s1),
		.key      (key)
	);

	// The digit is drawn from the state as it stands before this request.
	mpc_digit_mux u_digit_mux (
		.position   (mux_position_q),
		.duty       (duty_q),
		.forward    (forward_q),
		.tens_shown (tens_shown_q),
		.segments   (digit_segments)
	);

	assign wait_count_inc = wait_count_q + 8'd1;

	always_comb begin
		duty_d         = duty_q;
		forward_d      = forward_q;
		pin_state_d    = pin_state_q;
		wait_count_d   = wait_count_q;
		wait_active_d  = wait_active_q;
		mux_position_d = mux_position_q;
		tens_shown_d   = tens_shown_q;

		if (operation_s1 == OP_TICK) begin
			mux_position_d = mux_position_q + 2'd1;
			if (wait_active_q) begin
				wait_count_d = wait_count_inc;
				// The wait ends on the tick where the count meets the register.
				if (wait_count_inc == reverse_wait_ticks_q) begin
					pin_state_d   = forward_q ? PIN_REVERSE : PIN_FORWARD;
					forward_d     = !forward_q;
					wait_active_d = 1'b0;
					tens_shown_d  = 1'b1;
				end
			end
		end else if (!wait_active_q) begin
			if (key.set_duty) begin
				duty_d       = key.duty;
				tens_shown_d = 1'b1;
			end
			if (key.stop) begin
				pin_state_d = PIN_BRAKE;
			end
			if (key.reverse) begin
				pin_state_d   = PIN_OFF;
				wait_count_d  = 8'd0;
				wait_active_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_wait_ticks_q <= REVERSE_WAIT_RESET;
		end else if (cfg_we) begin
			reverse_wait_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q         <= 7'd0;
			forward_q      <= 1'b1;
			pin_state_q    <= PIN_BRAKE;
			wait_count_q   <= 8'd0;
			wait_active_q  <= 1'b0;
			mux_position_q <= POS_BLANK;
			tens_shown_q   <= 1'b0;
			valid_s2       <= 1'b0;
		end else begin
			valid_s2 <= load_s2 || (valid_s2 && !rsp.ready);
			if (load_s2) begin
				duty_q         <= duty_d;
				forward_q      <= forward_d;
				pin_state_q    <= pin_state_d;
				wait_count_q   <= wait_count_d;
				wait_active_q  <= wait_active_d;
				mux_position_q <= mux_position_d;
				tens_shown_q   <= tens_shown_d;
			end
		end
	end

	// Drive pins and the reversal flag come straight from the state, which
	// only changes when a new result loads.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			duty_compare_s2 <= wait_active_d ? 8'd0 : duty_to_compare(duty_d);
			if (operation_s1 == OP_TICK) begin
				digit_select_s2 <= mux_position_q;
				segments_s2     <= digit_segments;
			end else begin
				digit_select_s2 <= POS_BLANK;
				segments_s2     <= SEG_BLANK;
			end
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.duty_compare = duty_compare_s2;
	assign rsp.drive_pins   = pin_state_q;
	assign rsp.digit_select = digit_select_s2;
	assign rsp.segments     = segments_s2;
	assign rsp.reversing    = wait_active_q;

	// The drive stays off for the whole reversal wait.
	a_off_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		wait_active_q |-> pin_state_q == PIN_OFF)
		else $error("drive pins active during reversal wait");

	// A result shown during a reversal carries a zero compare value.
	a_zero_duty_reversing: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wait_active_q) |-> duty_compare_s2 == 8'd0)
		else $error("nonzero compare value while reversing");

	// A reversal always starts counting from zero.
	a_wait_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wait_active_q) |-> wait_count_q == 8'd0)
		else $error("reversal wait started with a stale count");

	// Once a key has set the duty, the tens digit is never blanked again.
	a_tens_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		tens_shown_q |=> tens_shown_q)
		else $error("tens digit blanked after being shown");

	// State only moves when a result is loaded.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(mux_position_q) && $stable(duty_q))
		else $error("state changed without a result");

endmodule

// File: src/mpc_key_decode.sv
// ----------------------------------------------------------------------------
// Motor panel key decoder
// Turns an active-low switch sample into a key action.
// ----------------------------------------------------------------------------
module mpc_key_decode (
	input  logic [5:0]  switches,
	output mpc_pkg::key_t key
);
	import mpc_pkg::*;

	always_comb begin
		key = '0;
		unique case (switches)
			SW_DUTY25: begin
				key.set_duty = 1'b1;
				key.duty     = 7'd25;
			end
			SW_DUTY50: begin
				key.set_duty = 1'b1;
				key.duty     = 7'd50;
			end
			SW_DUTY70: begin
				key.set_duty = 1'b1;
				key.duty     = 7'd70;
			end
			SW_DUTY90: begin
				key.set_duty = 1'b1;
				key.duty     = 7'd90;
			end
			SW_REVERSE: begin
				key.reverse = 1'b1;
			end
			SW_STOP: begin
				// Stop also sets the duty to zero.
				key.set_duty = 1'b1;
				key.stop     = 1'b1;
			end
			default: begin
				key = '0;
			end
		endcase
	end

endmodule

// File: src/mpc_digit_mux.sv
// ----------------------------------------------------------------------------
// Motor panel digit multiplexer
// Picks the segment pattern for the digit position driven this tick.
// ----------------------------------------------------------------------------
module mpc_digit_mux (
	input  logic [1:0] position,
	input  logic [6:0] duty,
	input  logic       forward,
	input  logic       tens_shown,
	output logic [7:0] segments
);
	import mpc_pkg::*;

	always_comb begin
		unique case (position)
			POS_SIGN:  segments = forward ? SEG_BLANK : SEG_MINUS;
			POS_TENS:  segments = tens_shown ? seg_digit(duty_tens(duty)) : SEG_BLANK;
			POS_UNITS: segments = seg_digit(duty_units(duty));
			default:   segments = SEG_BLANK;
		endcase
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor panel controller testbench
// Sends display ticks and switch samples through the request channel and
// checks every result against a cycle-free model of the panel state, with
// random gaps on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	import mpc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	// The keys that do something; everything else is a no-op pattern.
	localparam logic [5:0] KEY_CODES [6] = '{SW_DUTY25, SW_DUTY50, SW_DUTY70,
		SW_DUTY90, SW_REVERSE, SW_STOP};

	// Active-low seven-segment codes for 0..9.
	localparam logic [7:0] DIGIT_SEGS [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
		8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

	typedef struct packed {
		logic [7:0] duty_compare;
		logic [1:0] drive_pins;
		logic [1:0] digit_select;
		logic [7:0] segments;
		logic       reversing;
	} panel_result_t;

	// Panel state model plus the queue of results it has predicted.
	class panel_scoreboard;
		logic [6:0]    duty_pct;
		bit            dir_fwd;
		logic [1:0]    pins;
		logic [7:0]    tick_count;
		bit            in_reversal;
		logic [1:0]    digit_pos;
		bit            tens_lit;
		logic [7:0]    reverse_ticks;
		panel_result_t pending_results[$];
		int unsigned   errors;
		int unsigned   checked;
		int unsigned   ticks_seen;
		int unsigned   samples_seen;
		int unsigned   reversals_done;

		function new();
			duty_pct = 7'd0;
			dir_fwd = 1'b1;
			pins = PIN_BRAKE;
			tick_count = 8'd0;
			in_reversal = 1'b0;
			digit_pos = POS_BLANK;
			tens_lit = 1'b0;
			reverse_ticks = REVERSE_WAIT_RESET;
			errors = 0;
			checked = 0;
			ticks_seen = 0;
			samples_seen = 0;
			reversals_done = 0;
		endfunction

		function void set_reverse_ticks(input logic [7:0] value);
			reverse_ticks = value;
		endfunction

		function logic [7:0] display_pattern(input logic [1:0] pos);
			int unsigned tens;
			int unsigned units;
			logic [7:0]  pattern;
			tens = duty_pct / 10;
			units = duty_pct % 10;
			case (pos)
				POS_SIGN:  pattern = dir_fwd ? SEG_BLANK : SEG_MINUS;
				POS_TENS:  pattern = (!tens_lit || tens > 9) ? SEG_BLANK : DIGIT_SEGS[tens];
				POS_UNITS: pattern = DIGIT_SEGS[units];
				default:   pattern = SEG_BLANK;
			endcase
			return pattern;
		endfunction

		function void take_duty(input logic [6:0] pct);
			duty_pct = pct;
			tens_lit = 1'b1;
		endfunction

		// Advance the model by one accepted request and queue its result.
		function void note_request(input logic op, input logic [5:0] sw);
			panel_result_t r;
			int unsigned   scaled;
			r.digit_select = POS_BLANK;
			r.segments = SEG_BLANK;
			if (op == OP_TICK) begin
				ticks_seen++;
				r.digit_select = digit_pos;
				r.segments = display_pattern(digit_pos);
				digit_pos = digit_pos + 2'd1;
				if (in_reversal) begin
					tick_count = tick_count + 8'd1;
					// The digit above still shows the old direction.
					if (tick_count == reverse_ticks) begin
						pins = dir_fwd ? PIN_REVERSE : PIN_FORWARD;
						dir_fwd = !dir_fwd;
						in_reversal = 1'b0;
						tens_lit = 1'b1;
						reversals_done++;
					end
				end
			end else begin
				samples_seen++;
				if (!in_reversal) begin
					case (sw)
						SW_DUTY25:  take_duty(7'd25);
						SW_DUTY50:  take_duty(7'd50);
						SW_DUTY70:  take_duty(7'd70);
						SW_DUTY90:  take_duty(7'd90);
						SW_REVERSE: begin
							pins = PIN_OFF;
							tick_count = 8'd0;
							in_reversal = 1'b1;
						end
						SW_STOP: begin
							take_duty(7'd0);
							pins = PIN_BRAKE;
						end
						default: ;
					endcase
				end
			end
			scaled = duty_pct * 255 / 100;
			r.duty_compare = in_reversal ? 8'd0 : scaled[7:0];
			r.drive_pins = pins;
			r.reversing = in_reversal;
			pending_results.push_back(r);
		endfunction

		function void compare_field(input string field, input logic [7:0] want,
			input logic [7:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: result %0d %s mismatch: expected 0x%02h, actual 0x%02h",
					$time, checked, field, want, seen);
			end
		endfunction

		function void check_result(input panel_result_t got);
			panel_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding: expected none, actual %p",
					$time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("duty_compare", want.duty_compare, got.duty_compare);
			compare_field("drive_pins", want.drive_pins, got.drive_pins);
			compare_field("digit_select", want.digit_select, got.digit_select);
			compare_field("segments", want.segments, got.segments);
			compare_field("reversing", want.reversing, got.reversing);
			checked++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	mpc_req_if req_ch ();
	mpc_rsp_if rsp_ch ();

	motor_panel_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	panel_scoreboard board = new();
	panel_result_t   observed;
	bit              sender_burst;
	int unsigned     cycles;
	int unsigned     settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Results are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			observed.duty_compare = rsp_ch.duty_compare;
			observed.drive_pins = rsp_ch.drive_pins;
			observed.digit_select = rsp_ch.digit_select;
			observed.segments = rsp_ch.segments;
			observed.reversing = rsp_ch.reversing;
			board.check_result(observed);
		end
	end

	// Result side: random stalls, bursts with none, and one long hold-off
	// that lets the block fill up and push back on the request channel.
	initial begin : result_sink
		int unsigned hold;
		int unsigned roll;
		int unsigned sink_cycles;
		bit          pressure_done;
		bit          sink_burst;
		hold = 0;
		sink_cycles = 0;
		pressure_done = 1'b0;
		sink_burst = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			sink_cycles++;
			if (sink_cycles % 64 == 0)
				sink_burst = ($urandom_range(3) == 0);
			if (!pressure_done && board.checked >= 200) begin
				pressure_done = 1'b1;
				hold = 60;
			end else if (hold == 0 && !sink_burst) begin
				roll = $urandom_range(99);
				if (roll < 70)
					hold = 0;
				else if (roll < 95)
					hold = $urandom_range(3, 1);
				else
					hold = $urandom_range(20, 8);
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int unsigned sender_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (sender_burst || roll < 65)
			return 0;
		else if (roll < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(25, 8);
	endfunction

	// Mostly real keys, sometimes an arbitrary pattern.
	function automatic logic [5:0] random_switches();
		if ($urandom_range(99) < 80)
			return KEY_CODES[$urandom_range(5)];
		return 6'($urandom);
	endfunction

	// Offer one request after a random gap and wait until it is taken.
	task automatic send_request(input logic op, input logic [5:0] sw);
		int unsigned gap;
		gap = sender_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			req_ch.operation <= 1'($urandom);
			req_ch.switches <= 6'($urandom);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.switches <= sw;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		board.note_request(op, sw);
	endtask

	// During a reversal almost everything is a tick so that the wait runs
	// out; otherwise ticks and samples mix at the given rate.
	task automatic send_random_request(input int unsigned tick_pct);
		int unsigned roll;
		logic        op;
		if ((board.ticks_seen + board.samples_seen) % 40 == 0)
			sender_burst = ($urandom_range(2) == 0);
		roll = $urandom_range(99);
		if (board.in_reversal)
			op = (roll < 94) ? OP_TICK : OP_SAMPLE;
		else
			op = (roll < tick_pct) ? OP_TICK : OP_SAMPLE;
		send_request(op, (op == OP_TICK) ? 6'($urandom) : random_switches());
	endtask

	// Drop valid, let every result come back, then allow for the pipeline.
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reverse_ticks(input logic [7:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 8'($urandom);
		board.set_reverse_ticks(value);
		settings_used++;
	endtask

	task automatic run_phase(input logic [7:0] wait_ticks, input int unsigned count,
		input int unsigned tick_pct);
		write_reverse_ticks(wait_ticks);
		repeat (count) send_random_request(tick_pct);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_TICK;
		req_ch.switches = 6'd0;
		sender_burst = 1'b0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Display straight after reset: tens blank, units zero, forward.
		repeat (4) send_request(OP_TICK, 6'($urandom));
		// Idle pattern, every duty key, the all-pressed pattern and stop.
		send_request(OP_SAMPLE, 6'h3F);
		send_request(OP_SAMPLE, SW_DUTY25);
		send_request(OP_SAMPLE, SW_DUTY50);
		send_request(OP_SAMPLE, SW_DUTY70);
		send_request(OP_SAMPLE, SW_DUTY90);
		send_request(OP_SAMPLE, 6'h00);
		send_request(OP_SAMPLE, SW_STOP);
		// A duty key after stop leaves the motor braked.
		send_request(OP_SAMPLE, SW_DUTY25);
		repeat (4) send_request(OP_TICK, 6'($urandom));
		// Start a reversal at the reset wait; keys during it are ignored.
		send_request(OP_SAMPLE, SW_REVERSE);
		send_request(OP_SAMPLE, SW_DUTY90);
		send_request(OP_SAMPLE, SW_STOP);
		repeat (3) send_request(OP_TICK, 6'($urandom));
		// Shorten the wait while it runs; it ends two ticks later.
		write_reverse_ticks(8'd5);
		repeat (3) send_request(OP_TICK, 6'($urandom));
		send_request(OP_SAMPLE, SW_DUTY50);

		// Random phases: a short wait, the largest value, the shortest, and zero,
		// which means a full wrap of the tick counter.
		run_phase(8'($urandom_range(12, 2)), 80, 45);
		run_phase(8'd255, 300, 45);
		run_phase(8'd1, 80, 45);
		run_phase(8'd0, 300, 45);

		drain_results();
		repeat (8) @(posedge clk);
		$display("summary: %0d requests (%0d ticks, %0d switch samples), %0d results checked",
			board.ticks_seen + board.samples_seen, board.ticks_seen, board.samples_seen,
			board.checked);
		$display("summary: %0d reversals completed over %0d wait settings, %0d mismatches",
			board.reversals_done, settings_used + 1, board.errors);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
